### rtl/xcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcr_pkg;

   localparam logic [10:0] LARGE_BLOCK = 11'd1024;
   localparam logic [10:0] SMALL_BLOCK = 11'd128;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB  = 16'h8000;
   localparam logic [8:0]  COMPL_SUM = 9'd255;
   localparam logic [7:0]  ERR_SAT  = 8'd255;

   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CAN = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;

   localparam int  CSR_ADDR_W = 3;
   localparam logic REG_MAX_ERRORS = 1'b0;
   localparam logic REG_APP_BASE   = 1'b1;
   localparam logic [7:0]  MAX_ERRORS_RST = 8'd10;
   localparam logic [31:0] APP_BASE_RST   = 32'd0;

   typedef enum logic [2:0] {
      FN_BYTE    = 3'd0,
      FN_TIMEOUT = 3'd1,
      FN_FAULT   = 3'd2,
      FN_START   = 3'd3,
      FN_DONE    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_NUMBER = 3'd2,
      PH_COMPL  = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRCHI  = 3'd5,
      PH_CRCLO  = 3'd6,
      PH_FLASH  = 3'd7
   } phase_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        stage_valid;
      logic [9:0]  stage_offset;
      logic [7:0]  stage_data;
      logic        erase_req;
      logic        commit;
      logic [31:0] write_addr;
      logic        block_large;
      logic        finished;
      logic        aborted;
   } result_type;

   // dbl: the result goes out twice, the first beat without last
   typedef struct packed {
      logic       dbl;
      result_type res;
   } entry_type;

endpackage

`default_nettype wire

### rtl/xcr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module xcr_core
   import xcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_func,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [7:0]  max_errors,
   input  wire logic [31:0] app_base_address,
   output logic             push,
   output entry_type        push_entry,
   input  wire logic        push_ready
);

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   logic        in_valid_ff;
   logic [2:0]  func_ff;
   logic [7:0]  byte_ff;
   logic        fire;

   phase_type   phase_ff, phase_in;
   logic [10:0] count_ff, count_in;
   logic        large_ff, large_in;
   logic [7:0]  expected_ff, expected_in;
   logic [7:0]  errors_ff, errors_in;
   logic        first_done_ff, first_done_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  number_ff, number_in;
   logic [7:0]  compl_ff, compl_in;
   logic [7:0]  crc_hi_ff, crc_hi_in;

   logic        do_err;
   logic        do_abort;
   logic [7:0]  err_sat;
   logic [10:0] count_inc;
   logic [10:0] block_size;
   logic [8:0]  num_sum;
   logic        good;

   assign fire      = in_valid_ff && push_ready;
   assign req_ready = !in_valid_ff || push_ready;

   assign err_sat    = (errors_ff == ERR_SAT) ? errors_ff : errors_ff + 8'd1;
   assign count_inc  = count_ff + 11'd1;
   assign block_size = large_ff ? LARGE_BLOCK : SMALL_BLOCK;
   assign num_sum    = {1'b0, number_ff} + {1'b0, compl_ff};
   assign good       = (number_ff == expected_ff) && (num_sum == COMPL_SUM)
                       && ({crc_hi_ff, byte_ff} == crc_ff);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      large_in      = large_ff;
      expected_in   = expected_ff;
      errors_in     = errors_ff;
      first_done_in = first_done_ff;
      addr_in       = addr_ff;
      crc_in        = crc_ff;
      number_in     = number_ff;
      compl_in      = compl_ff;
      crc_hi_in     = crc_hi_ff;
      do_err        = 1'b0;
      do_abort      = 1'b0;

      unique case (func_type'(func_ff))
         FN_BYTE: begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (byte_ff == B_SOH || byte_ff == B_STX) begin
                     large_in = (byte_ff == B_STX);
                     count_in = '0;
                     crc_in   = '0;
                     phase_in = PH_NUMBER;
                  end else if (byte_ff == B_EOT || byte_ff == B_CAN) begin
                     phase_in = PH_IDLE;
                  end else begin
                     do_err = 1'b1;
                  end
               end
               PH_NUMBER: begin
                  number_in = byte_ff;
                  phase_in  = PH_COMPL;
               end
               PH_COMPL: begin
                  compl_in = byte_ff;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  crc_in   = crc_byte(crc_ff, byte_ff);
                  count_in = count_inc;
                  if (count_inc >= block_size) begin
                     phase_in = PH_CRCHI;
                  end
               end
               PH_CRCHI: begin
                  crc_hi_in = byte_ff;
                  phase_in  = PH_CRCLO;
               end
               PH_CRCLO: begin
                  if (!good) begin
                     do_err = 1'b1;
                  end else begin
                     phase_in = PH_FLASH;
                  end
               end
               default: begin
               end
            endcase
         end
         FN_TIMEOUT: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_FLASH) begin
            end else if (phase_ff == PH_HEADER && !first_done_ff) begin
            end else begin
               do_err = 1'b1;
            end
         end
         FN_FAULT: begin
            if (phase_ff == PH_FLASH) begin
               errors_in = max_errors;
               do_abort  = 1'b1;
            end
         end
         FN_START: begin
            errors_in     = '0;
            first_done_in = 1'b0;
            expected_in   = 8'd1;
            addr_in       = app_base_address;
            count_in      = '0;
            crc_in        = '0;
            phase_in      = PH_HEADER;
         end
         FN_DONE: begin
            if (phase_ff == PH_FLASH) begin
               expected_in   = expected_ff + 8'd1;
               addr_in       = addr_ff + {21'd0, block_size};
               first_done_in = 1'b1;
               phase_in      = PH_HEADER;
            end
         end
         default: begin
         end
      endcase

      if (do_err) begin
         errors_in = err_sat;
         if (err_sat >= max_errors) begin
            do_abort = 1'b1;
         end else begin
            phase_in = PH_HEADER;
         end
      end

      if (do_abort) begin
         phase_in = PH_IDLE;
      end
   end

   // result beats
   always_comb begin
      push       = 1'b0;
      push_entry = '0;

      unique case (func_type'(func_ff))
         FN_BYTE: begin
            unique case (phase_ff)
               PH_HEADER: begin
                  if (byte_ff == B_EOT) begin
                     push                    = 1'b1;
                     push_entry.res.tx_valid = 1'b1;
                     push_entry.res.tx_byte  = B_ACK;
                     push_entry.res.finished = 1'b1;
                  end else if (byte_ff == B_CAN) begin
                     push                   = 1'b1;
                     push_entry.res.aborted = 1'b1;
                  end
               end
               PH_DATA: begin
                  push                        = 1'b1;
                  push_entry.res.stage_valid  = 1'b1;
                  push_entry.res.stage_offset = count_ff[9:0];
                  push_entry.res.stage_data   = byte_ff;
               end
               PH_CRCLO: begin
                  if (good) begin
                     push                       = 1'b1;
                     push_entry.res.erase_req   = !first_done_ff;
                     push_entry.res.commit      = 1'b1;
                     push_entry.res.write_addr  = addr_ff;
                     push_entry.res.block_large = large_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         FN_TIMEOUT: begin
            if (phase_ff == PH_HEADER && !first_done_ff) begin
               push                    = 1'b1;
               push_entry.res.tx_valid = 1'b1;
               push_entry.res.tx_byte  = B_C;
            end
         end
         FN_DONE: begin
            if (phase_ff == PH_FLASH) begin
               push                    = 1'b1;
               push_entry.res.tx_valid = 1'b1;
               push_entry.res.tx_byte  = B_ACK;
            end
         end
         default: begin
         end
      endcase

      if (do_err && !do_abort) begin
         push                    = 1'b1;
         push_entry              = '0;
         push_entry.res.tx_valid = 1'b1;
         push_entry.res.tx_byte  = B_NAK;
      end

      if (do_abort) begin
         push                    = 1'b1;
         push_entry              = '0;
         push_entry.dbl          = 1'b1;
         push_entry.res.tx_valid = 1'b1;
         push_entry.res.tx_byte  = B_CAN;
         push_entry.res.aborted  = 1'b1;
      end

      if (!fire) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         func_ff <= req_func;
         byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         large_ff      <= 1'b0;
         expected_ff   <= 8'd1;
         errors_ff     <= '0;
         first_done_ff <= 1'b0;
         addr_ff       <= '0;
         crc_ff        <= '0;
         number_ff     <= '0;
         compl_ff      <= '0;
         crc_hi_ff     <= '0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         large_ff      <= large_in;
         expected_ff   <= expected_in;
         errors_ff     <= errors_in;
         first_done_ff <= first_done_in;
         addr_ff       <= addr_in;
         crc_ff        <= crc_in;
         number_ff     <= number_in;
         compl_ff      <= compl_in;
         crc_hi_ff     <= crc_hi_in;
      end
   end

endmodule

`default_nettype wire

### rtl/xcr_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

module xcr_obuf
   import xcr_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   output logic           push_ready,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output result_type     rsp_res,
   output logic           rsp_last
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       second_ff;
   logic       beat;
   logic       pop;
   entry_type  head;

   assign head       = mem_ff[rd_ptr_ff];
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_res    = head.res;
   assign rsp_last   = !head.dbl || second_ff;
   assign beat       = rsp_valid && rsp_ready;
   assign pop        = beat && rsp_last;
   assign push_ready = (count_ff != 2'd2) || pop;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         second_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            second_ff <= 1'b0;
         end else if (beat) begin
            second_ff <= 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/xmodem_crc_receiver.sv
// XMODEM-CRC receiver, 128-byte (SOH) and 1024-byte (STX) blocks.
// req channel: one beat per event; req_func selects received byte, line
// timeout, flash fault, session start or flash done; req_rx_byte is the byte.
// rsp channel: zero, one or two beats per request beat, in order; rsp_last
// marks the final beat belonging to a request. Data bytes go out as staging
// beats, a verified block as a commit beat, control bytes as tx beats.
// csr: APB-style, max_errors at 0x0, app_base_address at 0x4; write only
// while the block is idle. pready is tied high.
// Path: a request beat is registered in the input register, decoded
// combinationally, and its result lands in a two-entry output queue, which
// drives rsp_valid.
// Throughput: one request beat per cycle while results are taken at the
// same rate; a CAN CAN abort needs two rsp beats. The queue depth sets how
// far the sides decouple.
// A stalled rsp channel fills the queue, after which req_ready drops and the
// held request waits in the input register. Reset (synchronous) returns the
// parser to idle, empties the queue and restores the registers.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_crc_receiver
   import xcr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_func,
   input  wire logic [7:0]            req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_tx_valid,
   output logic [7:0]                 rsp_tx_byte,
   output logic                       rsp_stage_valid,
   output logic [9:0]                 rsp_stage_offset,
   output logic [7:0]                 rsp_stage_data,
   output logic                       rsp_erase_req,
   output logic                       rsp_commit,
   output logic [31:0]                rsp_write_addr,
   output logic                       rsp_block_large,
   output logic                       rsp_finished,
   output logic                       rsp_aborted,
   output logic                       rsp_last,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [7:0]  max_errors_ff;
   logic [31:0] app_base_ff;
   logic        push;
   logic        push_ready;
   entry_type   push_entry;
   result_type  res;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff <= MAX_ERRORS_RST;
         app_base_ff   <= APP_BASE_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_MAX_ERRORS: max_errors_ff <= csr_pwdata[7:0];
            REG_APP_BASE:   app_base_ff   <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MAX_ERRORS: csr_prdata = {24'd0, max_errors_ff};
         REG_APP_BASE:   csr_prdata = app_base_ff;
         default:        csr_prdata = '0;
      endcase
   end

   xcr_core u_core (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_rx_byte      (req_rx_byte),
      .max_errors       (max_errors_ff),
      .app_base_address (app_base_ff),
      .push             (push),
      .push_entry       (push_entry),
      .push_ready       (push_ready)
   );

   xcr_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res    (res),
      .rsp_last   (rsp_last)
   );

   assign rsp_tx_valid     = res.tx_valid;
   assign rsp_tx_byte      = res.tx_byte;
   assign rsp_stage_valid  = res.stage_valid;
   assign rsp_stage_offset = res.stage_offset;
   assign rsp_stage_data   = res.stage_data;
   assign rsp_erase_req    = res.erase_req;
   assign rsp_commit       = res.commit;
   assign rsp_write_addr   = res.write_addr;
   assign rsp_block_large  = res.block_large;
   assign rsp_finished     = res.finished;
   assign rsp_aborted      = res.aborted;

   // first CAN of an abort is always followed by the second
   a_can_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_aborted && !rsp_last
      |=> rsp_valid && rsp_aborted && rsp_last && rsp_tx_byte == B_CAN)
      else $error("abort beat not followed by its pair");

   a_erase_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_erase_req |-> rsp_commit && !rsp_stage_valid && !rsp_tx_valid)
      else $error("erase request outside a commit beat");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat straight after reset");

endmodule

`default_nettype wire

### tb/sv/xmodem_rx_checker.sv
`timescale 1ns / 1ps

module xmodem_rx_checker
   import xcr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [2:0]            req_func,
   input  logic [7:0]            req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_tx_valid,
   input  logic [7:0]            rsp_tx_byte,
   input  logic                  rsp_stage_valid,
   input  logic [9:0]            rsp_stage_offset,
   input  logic [7:0]            rsp_stage_data,
   input  logic                  rsp_erase_req,
   input  logic                  rsp_commit,
   input  logic [31:0]           rsp_write_addr,
   input  logic                  rsp_block_large,
   input  logic                  rsp_finished,
   input  logic                  rsp_aborted,
   input  logic                  rsp_last,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   input  logic [31:0]           csr_prdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    outstanding,
   output int                    checked
);

   typedef struct packed {
      result_type res;
      logic       last;
   } rsp_beat;

   rsp_beat     awaited[$];

   logic [7:0]  max_err;
   logic [31:0] app_base;

   phase_type   parse_phase;
   logic [10:0] byte_cnt;
   logic        large_blk;
   logic [7:0]  next_num;
   logic [7:0]  err_cnt;
   logic        first_done;
   logic [31:0] flash_addr;
   logic [15:0] crc;
   logic [7:0]  num_rx;
   logic [7:0]  compl_rx;
   logic [7:0]  crc_hi;

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      int          i;
      v = c ^ {b, 8'h00};
      for (i = 0; i < 8; i++) begin
         if ((v & CRC_MSB) != 0) v = (v << 1) ^ CRC_POLY;
         else v = v << 1;
      end
      return v;
   endfunction

   function automatic logic [10:0] blk_size();
      return large_blk ? LARGE_BLOCK : SMALL_BLOCK;
   endfunction

   task automatic emit_tx(input logic [7:0] code, input logic fin, input logic abt,
                          input logic lst);
      rsp_beat e;
      e = '0;
      e.res.tx_valid = 1'b1;
      e.res.tx_byte  = code;
      e.res.finished = fin;
      e.res.aborted  = abt;
      e.last         = lst;
      awaited.push_back(e);
   endtask

   task automatic cancel_transfer();
      emit_tx(B_CAN, 1'b0, 1'b1, 1'b0);
      emit_tx(B_CAN, 1'b0, 1'b1, 1'b1);
      parse_phase = PH_IDLE;
   endtask

   task automatic note_error();
      if (err_cnt != ERR_SAT) err_cnt++;
      if (err_cnt >= max_err) begin
         cancel_transfer();
      end else begin
         parse_phase = PH_HEADER;
         emit_tx(B_NAK, 1'b0, 1'b0, 1'b1);
      end
   endtask

   task automatic on_rx_byte(input logic [7:0] b);
      rsp_beat     e;
      logic [15:0] crc_rx;
      e = '0;
      case (parse_phase)
         PH_HEADER: begin
            if (b == B_SOH || b == B_STX) begin
               large_blk   = (b == B_STX);
               byte_cnt    = '0;
               crc         = '0;
               parse_phase = PH_NUMBER;
            end else if (b == B_EOT) begin
               parse_phase = PH_IDLE;
               emit_tx(B_ACK, 1'b1, 1'b0, 1'b1);
            end else if (b == B_CAN) begin
               parse_phase   = PH_IDLE;
               e.res.aborted = 1'b1;
               e.last        = 1'b1;
               awaited.push_back(e);
            end else begin
               note_error();
            end
         end
         PH_NUMBER: begin
            num_rx      = b;
            parse_phase = PH_COMPL;
         end
         PH_COMPL: begin
            compl_rx    = b;
            parse_phase = PH_DATA;
         end
         PH_DATA: begin
            e.res.stage_valid  = 1'b1;
            e.res.stage_offset = byte_cnt[9:0];
            e.res.stage_data   = b;
            e.last             = 1'b1;
            awaited.push_back(e);
            crc      = crc16_step(crc, b);
            byte_cnt = byte_cnt + 11'd1;
            if (byte_cnt >= blk_size()) parse_phase = PH_CRCHI;
         end
         PH_CRCHI: begin
            crc_hi      = b;
            parse_phase = PH_CRCLO;
         end
         PH_CRCLO: begin
            crc_rx = {crc_hi, b};
            if (num_rx == next_num && ({1'b0, num_rx} + {1'b0, compl_rx}) == COMPL_SUM
                && crc_rx == crc) begin
               e.res.erase_req   = !first_done;
               e.res.commit      = 1'b1;
               e.res.write_addr  = flash_addr;
               e.res.block_large = large_blk;
               e.last            = 1'b1;
               awaited.push_back(e);
               parse_phase = PH_FLASH;
            end else begin
               note_error();
            end
         end
         default: ;
      endcase
   endtask

   task automatic on_event(input logic [2:0] f, input logic [7:0] b);
      case (f)
         FN_BYTE: on_rx_byte(b);
         FN_TIMEOUT: begin
            if (parse_phase != PH_IDLE && parse_phase != PH_FLASH) begin
               if (parse_phase == PH_HEADER && !first_done) emit_tx(B_C, 1'b0, 1'b0, 1'b1);
               else note_error();
            end
         end
         FN_FAULT: begin
            if (parse_phase == PH_FLASH) begin
               err_cnt = max_err;
               cancel_transfer();
            end
         end
         FN_START: begin
            err_cnt     = '0;
            first_done  = 1'b0;
            next_num    = 8'd1;
            flash_addr  = app_base;
            byte_cnt    = '0;
            crc         = '0;
            parse_phase = PH_HEADER;
         end
         FN_DONE: begin
            if (parse_phase == PH_FLASH) begin
               next_num    = next_num + 8'd1;
               flash_addr  = flash_addr + blk_size();
               first_done  = 1'b1;
               parse_phase = PH_HEADER;
               emit_tx(B_ACK, 1'b0, 1'b0, 1'b1);
            end
         end
         default: ;
      endcase
   endtask

   task automatic match_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: rsp %s expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   task automatic take_beat();
      rsp_beat want;
      if (awaited.size() == 0) begin
         $display("%0t: rsp beat expected none, got tx %0b/%0h stage %0b/%0h commit %0b",
                  $time, rsp_tx_valid, rsp_tx_byte, rsp_stage_valid, rsp_stage_data,
                  rsp_commit);
         failures++;
      end else begin
         want = awaited.pop_front();
         checked++;
         match_field("tx_valid", want.res.tx_valid, rsp_tx_valid);
         match_field("tx_byte", want.res.tx_byte, rsp_tx_byte);
         match_field("stage_valid", want.res.stage_valid, rsp_stage_valid);
         match_field("stage_offset", want.res.stage_offset, rsp_stage_offset);
         match_field("stage_data", want.res.stage_data, rsp_stage_data);
         match_field("erase_req", want.res.erase_req, rsp_erase_req);
         match_field("commit", want.res.commit, rsp_commit);
         match_field("write_addr", want.res.write_addr, rsp_write_addr);
         match_field("block_large", want.res.block_large, rsp_block_large);
         match_field("finished", want.res.finished, rsp_finished);
         match_field("aborted", want.res.aborted, rsp_aborted);
         match_field("last", want.last, rsp_last);
      end
   endtask

   initial begin
      failures    = 0;
      outstanding = 0;
      checked     = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         awaited.delete();
         max_err     = MAX_ERRORS_RST;
         app_base    = APP_BASE_RST;
         parse_phase = PH_IDLE;
         byte_cnt    = '0;
         large_blk   = 1'b0;
         next_num    = 8'd1;
         err_cnt     = '0;
         first_done  = 1'b0;
         flash_addr  = '0;
         crc         = '0;
         num_rx      = '0;
         compl_rx    = '0;
         crc_hi      = '0;
      end else begin
         // response side first so a beat is never matched against its own request
         if (rsp_valid && rsp_ready) take_beat();
         if (req_valid && req_ready) on_event(req_func, req_rx_byte);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == REG_APP_BASE) app_base = csr_pwdata;
               else max_err = csr_pwdata[7:0];
            end else begin
               match_field("csr prdata", (csr_paddr[2] == REG_APP_BASE) ? app_base
                           : {24'h0, max_err}, csr_prdata);
            end
         end
      end
      outstanding = awaited.size();
   end

endmodule

### tb/sv/tb_xmodem_crc_receiver.sv
`timescale 1ns / 1ps

module tb_xmodem_crc_receiver;
   import xcr_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int ITEM_TARGET  = 1600;
   localparam int PHASE_ITEMS  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   // func codes outside the defined set; the block must ignore them
   localparam logic [2:0] FN_SPARE_LO = 3'd5;
   localparam logic [2:0] FN_SPARE_HI = 3'd7;

   typedef enum {FLAW_NONE, FLAW_NUMBER, FLAW_COMPL, FLAW_CRC, FLAW_CUT} flaw_kind;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [2:0]            req_func;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_tx_valid;
   logic [7:0]            rsp_tx_byte;
   logic                  rsp_stage_valid;
   logic [9:0]            rsp_stage_offset;
   logic [7:0]            rsp_stage_data;
   logic                  rsp_erase_req;
   logic                  rsp_commit;
   logic [31:0]           rsp_write_addr;
   logic                  rsp_block_large;
   logic                  rsp_finished;
   logic                  rsp_aborted;
   logic                  rsp_last;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int checked;

   int cycle_count = 0;
   int events_sent;
   int transfers;
   int blocks_sent;
   int large_sent;
   int settings_used;
   int calm_left;
   bit hold_rsp;

   // sender-side view of the transfer, enough to keep sequences well formed
   int         errs;
   int         max_err_now;
   logic [7:0] next_num;
   bit         first_ok;
   bit         transfer_live;

   xmodem_crc_receiver u_top (.*);

   xmodem_rx_checker u_chk (.*);

   initial begin
      clock = 1'b0;
   end

   always begin
      #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still awaited", cycle_count,
                  outstanding);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(16, 40);
   endfunction

   function automatic logic [15:0] crc_after(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      int          i;
      v = c ^ {b, 8'h00};
      for (i = 0; i < 8; i++) begin
         if ((v & CRC_MSB) != 0) v = (v << 1) ^ CRC_POLY;
         else v = v << 1;
      end
      return v;
   endfunction

   task automatic send_event(input logic [2:0] f, input logic [7:0] b);
      int n;
      @(negedge clock);
      if (calm_left > 0) begin
         calm_left--;
         n = 0;
      end else begin
         n = idle_len();
         if ($urandom_range(0, 99) == 0) calm_left = $urandom_range(40, 150);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= f;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      events_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_event(FN_BYTE, b);
   endtask

   task automatic csr_access(input logic wr, input logic idx, input logic [31:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic apply_config(input logic [7:0] me, input logic [31:0] base);
      settle();
      csr_access(1'b1, REG_MAX_ERRORS, {24'h0, me});
      csr_access(1'b1, REG_APP_BASE, base);
      csr_access(1'b0, REG_MAX_ERRORS, '0);
      csr_access(1'b0, REG_APP_BASE, '0);
      max_err_now = me;
      settings_used++;
   endtask

   task automatic count_err();
      errs++;
      if (errs >= max_err_now) transfer_live = 1'b0;
   endtask

   task automatic send_block(input bit big, input flaw_kind fl, input bit squeeze);
      int          size;
      int          i;
      int          cut_at;
      int          r;
      logic [15:0] crc;
      logic [7:0]  step;
      logic [7:0]  num_b;
      logic [7:0]  compl_b;
      logic [7:0]  b;
      size    = big ? LARGE_BLOCK : SMALL_BLOCK;
      step    = 8'($urandom_range(1, 255));
      num_b   = (fl == FLAW_NUMBER) ? next_num + step : next_num;
      compl_b = 8'hFF - num_b;
      if (fl == FLAW_COMPL) compl_b = compl_b ^ step;
      cut_at  = (fl == FLAW_CUT) ? $urandom_range(0, size + 3) : -1;
      crc     = '0;
      blocks_sent++;
      if (big) large_sent++;
      send_byte(big ? B_STX : B_SOH);
      for (i = 0; i < size + 4; i++) begin
         if (i == cut_at) begin
            send_event(FN_TIMEOUT, 8'($urandom));
            count_err();
            return;
         end
         if (squeeze && i == 64) hold_rsp = 1'b1;
         if (i == 0) begin
            b = num_b;
         end else if (i == 1) begin
            b = compl_b;
         end else if (i < size + 2) begin
            b   = 8'($urandom);
            crc = crc_after(crc, b);
         end else begin
            if (i == size + 2 && fl == FLAW_CRC) crc = crc ^ {8'h00, step};
            b = (i == size + 2) ? crc[15:8] : crc[7:0];
         end
         send_byte(b);
      end
      if (fl != FLAW_NONE) begin
         count_err();
         return;
      end
      // block committed: stray line events while flash is busy are ignored
      r = $urandom_range(0, 99);
      if (r < 15) send_event((r < 8) ? FN_TIMEOUT : FN_BYTE, 8'($urandom));
      if (r >= 92) begin
         send_event(FN_FAULT, 8'($urandom));
         transfer_live = 1'b0;
      end else begin
         send_event(FN_DONE, 8'($urandom));
         next_num = next_num + 8'd1;
         first_ok = 1'b1;
      end
   endtask

   task automatic run_transfer(input bit with_large);
      int         nblk;
      int         k;
      int         r;
      bit         big;
      flaw_kind   fl;
      logic [7:0] hb;
      logic [2:0] fv;
      transfers++;
      send_event(FN_START, 8'($urandom));
      errs          = 0;
      first_ok      = 1'b0;
      next_num      = 8'd1;
      transfer_live = 1'b1;
      nblk          = $urandom_range(1, 5);
      for (k = 0; k < nblk && transfer_live; k++) begin
         r = $urandom_range(0, 99);
         if (with_large && k == 0) begin
            send_block(1'b1, FLAW_NONE, 1'b1);
         end else if (r < 6) begin
            send_event(FN_TIMEOUT, 8'($urandom));
            if (first_ok) count_err();
         end else if (r < 11) begin
            do hb = 8'($urandom);
            while (hb == B_SOH || hb == B_STX || hb == B_EOT || hb == B_CAN);
            send_byte(hb);
            count_err();
         end else if (r < 16) begin
            fv = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
            case ($urandom_range(0, 2))
               0: send_event(fv, 8'($urandom));
               1: send_event(FN_DONE, 8'($urandom));
               default: send_event(FN_FAULT, 8'($urandom));
            endcase
         end else begin
            r = $urandom_range(0, 99);
            if (r < 72) fl = FLAW_NONE;
            else if (r < 79) fl = FLAW_NUMBER;
            else if (r < 86) fl = FLAW_COMPL;
            else if (r < 93) fl = FLAW_CRC;
            else fl = FLAW_CUT;
            big = (fl == FLAW_CUT) && ($urandom_range(0, 3) == 0);
            send_block(big, fl, 1'b0);
         end
      end
      if (transfer_live) begin
         r = $urandom_range(0, 99);
         if (r < 80) send_byte(B_EOT);
         else if (r < 90) send_byte(B_CAN);
      end
   endtask

   // result side: random back-pressure, plus one long hold when asked
   initial begin : rsp_side
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            n = (calm_left > 0) ? 0 : idle_len();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      int         p;
      int         t0;
      logic [7:0] me_pick;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = FN_BYTE;
      req_rx_byte   = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      events_sent   = 0;
      transfers     = 0;
      blocks_sent   = 0;
      large_sent    = 0;
      settings_used = 0;
      calm_left     = 0;
      hold_rsp      = 1'b0;
      max_err_now   = MAX_ERRORS_RST;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // idle: everything ignored
      send_byte(8'hFF);
      send_event(FN_TIMEOUT, 8'h00);
      send_event(FN_FAULT, 8'hFF);
      send_event(FN_DONE, 8'h00);
      send_event(FN_SPARE_LO, 8'h00);
      send_event(FN_SPARE_HI, 8'hFF);
      // session: C on timeout, NAK on junk header
      send_event(FN_START, 8'h00);
      send_event(FN_TIMEOUT, 8'h00);
      send_byte(8'h00);
      send_byte(B_ACK);
      // block broken off by a timeout after two data beats
      send_byte(B_SOH);
      send_byte(8'h01);
      send_byte(8'hFE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_event(FN_TIMEOUT, 8'h00);
      send_event(FN_DONE, 8'h00);
      send_byte(B_CAN);
      send_event(FN_START, 8'hFF);
      send_byte(B_EOT);
      send_byte(B_SOH);

      p = 0;
      while (events_sent < ITEM_TARGET) begin
         case (p % 4)
            0: apply_config(8'd255, 32'hFFFF_FF80);
            1: apply_config(8'd1, 32'hFFFF_FFFF);
            2: begin
               me_pick = 8'($urandom_range(2, 12));
               apply_config(me_pick, $urandom);
            end
            default: apply_config(MAX_ERRORS_RST, APP_BASE_RST);
         endcase
         t0 = events_sent;
         while (events_sent - t0 < PHASE_ITEMS && events_sent < ITEM_TARGET)
            run_transfer(p == 0 && events_sent == t0);
         p++;
      end

      settle();
      $display("covered %0d events in %0d transfers under %0d register settings",
               events_sent, transfers, settings_used + 1);
      $display("%0d blocks offered (%0d large), %0d result beats compared",
               blocks_sent, large_sent, checked);
      if (failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
